// ----- sv/i2cmts_pkg.sv -----
// Shared types and constants for the I2C master transaction sequencer.
package i2cmts_pkg;

  localparam int MAX_ADDRESS_BYTES = 4;
  localparam int COUNT_BITS        = 16;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_SLA   = 3'd2,
    PH_ADDR  = 3'd3,
    PH_TX    = 3'd4,
    PH_RX    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_ACK     = 3'd3,
    ACT_NACK    = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_RELEASE = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_BUSY  = 2'd1,
    ERR_NACK  = 2'd2,
    ERR_OTHER = 2'd3
  } error_t;

  // Bus status codes, low three bits masked off.
  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_RX_ACK    = 8'h50;
  localparam logic [7:0] ST_RX_NACK   = 8'h58;

  typedef struct packed {
    action_t    action;
    logic [7:0] out_byte;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    error_t     error_code;
  } result_t;

endpackage

// ----- sv/i2cmts_core.sv -----
// Transaction state and per-transaction step logic of the I2C sequencer.
module i2cmts_core #(
  parameter int MAX_ADDRESS_BYTES = i2cmts_pkg::MAX_ADDRESS_BYTES,
  parameter int COUNT_BITS        = i2cmts_pkg::COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                mode,
  input  logic                is_read,
  input  logic [6:0]          device_address,
  input  logic [31:0]         register_address,
  input  logic [2:0]          register_address_bytes,
  input  logic [15:0]         byte_count,
  input  logic [7:0]          status_code,
  input  logic [7:0]          bus_byte,
  input  logic [7:0]          tx_byte,
  output i2cmts_pkg::result_t res,
  output logic                busy
);

  localparam int AB_BITS = $clog2(MAX_ADDRESS_BYTES + 1);

  i2cmts_pkg::phase_t     phase_r, phase_nxt;
  logic                   reading_r, reading_nxt;
  logic [6:0]             target_r, target_nxt;
  logic [31:0]            shift_r, shift_nxt;
  logic [AB_BITS-1:0]     abytes_r, abytes_nxt;
  logic [COUNT_BITS-1:0]  dbytes_r, dbytes_nxt;

  logic [2:0]             n_sat;
  logic [31:0]            shift_load;
  logic [7:0]             st;
  logic [COUNT_BITS-1:0]  rx_left;

  // Outcome of moving on after an ack in a write
  i2cmts_pkg::action_t    wn_act;
  logic [7:0]             wn_byte;
  i2cmts_pkg::phase_t     wn_phase;
  logic [31:0]            wn_shift;
  logic [AB_BITS-1:0]     wn_ab;
  logic [COUNT_BITS-1:0]  wn_db;
  logic                   wn_done;

  assign busy = (phase_r != i2cmts_pkg::PH_IDLE);
  assign st   = status_code & i2cmts_pkg::STATUS_MASK;

  assign n_sat = (register_address_bytes > 3'(MAX_ADDRESS_BYTES)) ?
                 3'(MAX_ADDRESS_BYTES) : register_address_bytes;
  // Left-align the low n bytes so the MSB byte sits in bits 31..24
  assign shift_load = register_address << {2'(3'd4 - n_sat), 3'b000};

  assign rx_left = (dbytes_r != '0) ? dbytes_r - COUNT_BITS'(1) : dbytes_r;

  always_comb begin
    wn_act   = i2cmts_pkg::ACT_SEND;
    wn_byte  = 8'h00;
    wn_phase = phase_r;
    wn_shift = shift_r;
    wn_ab    = abytes_r;
    wn_db    = dbytes_r;
    wn_done  = 1'b0;
    if (abytes_r != '0) begin
      wn_byte  = shift_r[31:24];
      wn_shift = {shift_r[23:0], 8'h00};
      wn_ab    = abytes_r - AB_BITS'(1);
      wn_phase = i2cmts_pkg::PH_ADDR;
    end else if (dbytes_r != '0) begin
      wn_byte  = tx_byte;
      wn_db    = dbytes_r - COUNT_BITS'(1);
      wn_phase = i2cmts_pkg::PH_TX;
    end else begin
      wn_act   = i2cmts_pkg::ACT_STOP;
      wn_done  = 1'b1;
      wn_phase = i2cmts_pkg::PH_IDLE;
    end
  end

  always_comb begin
    res         = '0;
    phase_nxt   = phase_r;
    reading_nxt = reading_r;
    target_nxt  = target_r;
    shift_nxt   = shift_r;
    abytes_nxt  = abytes_r;
    dbytes_nxt  = dbytes_r;
    if (!mode) begin
      if (phase_r == i2cmts_pkg::PH_IDLE) begin
        reading_nxt = is_read;
        target_nxt  = device_address;
        dbytes_nxt  = COUNT_BITS'(byte_count);
        if (n_sat == 3'd0 || is_read) begin
          shift_nxt  = '0;
          abytes_nxt = '0;
        end else begin
          shift_nxt  = shift_load;
          abytes_nxt = AB_BITS'(n_sat);
        end
        res.action = i2cmts_pkg::ACT_START;
        phase_nxt  = i2cmts_pkg::PH_START;
      end
    end else begin
      unique case (phase_r)
        i2cmts_pkg::PH_START: begin
          if (st == i2cmts_pkg::ST_START || st == i2cmts_pkg::ST_RSTART) begin
            res.action   = i2cmts_pkg::ACT_SEND;
            res.out_byte = {target_r, reading_r};
            phase_nxt    = i2cmts_pkg::PH_SLA;
          end else begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_BUSY;
            phase_nxt      = i2cmts_pkg::PH_IDLE;
          end
        end
        i2cmts_pkg::PH_SLA, i2cmts_pkg::PH_ADDR, i2cmts_pkg::PH_TX: begin
          if (phase_r == i2cmts_pkg::PH_SLA && reading_r) begin
            if (st == i2cmts_pkg::ST_SLAR_ACK) begin
              if (dbytes_r == '0) begin
                res.action   = i2cmts_pkg::ACT_STOP;
                res.done_res = 1'b1;
                phase_nxt    = i2cmts_pkg::PH_IDLE;
              end else begin
                res.action = (dbytes_r == COUNT_BITS'(1)) ?
                             i2cmts_pkg::ACT_NACK : i2cmts_pkg::ACT_ACK;
                phase_nxt  = i2cmts_pkg::PH_RX;
              end
            end else begin
              res.done_res = 1'b1;
              phase_nxt    = i2cmts_pkg::PH_IDLE;
              if (st == i2cmts_pkg::ST_SLAR_NACK) begin
                res.action     = i2cmts_pkg::ACT_STOP;
                res.error_code = i2cmts_pkg::ERR_NACK;
              end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
                res.action     = i2cmts_pkg::ACT_RELEASE;
                res.error_code = i2cmts_pkg::ERR_OTHER;
              end else begin
                res.action     = i2cmts_pkg::ACT_STOP;
                res.error_code = i2cmts_pkg::ERR_OTHER;
              end
            end
          end else if ((phase_r == i2cmts_pkg::PH_SLA && st == i2cmts_pkg::ST_SLAW_ACK) ||
                       (phase_r != i2cmts_pkg::PH_SLA && st == i2cmts_pkg::ST_DATA_ACK))
          begin
            res.action   = wn_act;
            res.out_byte = wn_byte;
            res.done_res = wn_done;
            phase_nxt    = wn_phase;
            shift_nxt    = wn_shift;
            abytes_nxt   = wn_ab;
            dbytes_nxt   = wn_db;
          end else begin
            res.done_res = 1'b1;
            phase_nxt    = i2cmts_pkg::PH_IDLE;
            if ((phase_r == i2cmts_pkg::PH_SLA && st == i2cmts_pkg::ST_SLAW_NACK) ||
                (phase_r != i2cmts_pkg::PH_SLA && st == i2cmts_pkg::ST_DATA_NACK)) begin
              res.action     = i2cmts_pkg::ACT_STOP;
              res.error_code = i2cmts_pkg::ERR_NACK;
            end else if (st == i2cmts_pkg::ST_ARB_LOST) begin
              res.action     = i2cmts_pkg::ACT_RELEASE;
              res.error_code = i2cmts_pkg::ERR_OTHER;
            end else begin
              res.action     = i2cmts_pkg::ACT_STOP;
              res.error_code = i2cmts_pkg::ERR_OTHER;
            end
          end
        end
        i2cmts_pkg::PH_RX: begin
          if (st == i2cmts_pkg::ST_RX_ACK || st == i2cmts_pkg::ST_RX_NACK) begin
            res.rx_byte  = bus_byte;
            res.rx_valid = 1'b1;
            dbytes_nxt   = rx_left;
            if (st == i2cmts_pkg::ST_RX_NACK || rx_left == '0) begin
              res.action   = i2cmts_pkg::ACT_STOP;
              res.done_res = 1'b1;
              phase_nxt    = i2cmts_pkg::PH_IDLE;
            end else begin
              res.action = (rx_left == COUNT_BITS'(1)) ?
                           i2cmts_pkg::ACT_NACK : i2cmts_pkg::ACT_ACK;
            end
          end else begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_OTHER;
            phase_nxt      = i2cmts_pkg::PH_IDLE;
            res.action     = (st == i2cmts_pkg::ST_ARB_LOST) ?
                             i2cmts_pkg::ACT_RELEASE : i2cmts_pkg::ACT_STOP;
          end
        end
        default: begin
          phase_nxt = i2cmts_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cmts_pkg::PH_IDLE;
      reading_r <= 1'b0;
      target_r  <= '0;
      shift_r   <= '0;
      abytes_r  <= '0;
      dbytes_r  <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      reading_r <= reading_nxt;
      target_r  <= target_nxt;
      shift_r   <= shift_nxt;
      abytes_r  <= abytes_nxt;
      dbytes_r  <= dbytes_nxt;
    end
  end

endmodule

// ----- sv/i2c_master_transaction_sequencer.sv -----
// Top level of the I2C master transaction sequencer: handshake and result register.
// The result is registered and shows on out_ in the cycle after acceptance.
// Throughput: one transaction per cycle; the transaction state updates in the same
// cycle it is accepted, and the result register frees whenever out_stall is low.
// Reset (synchronous, rst_n low): phase returns to idle, all state clears and the
// result register is emptied.
module i2c_master_transaction_sequencer #(
  parameter int MAX_ADDRESS_BYTES = i2cmts_pkg::MAX_ADDRESS_BYTES,
  parameter int COUNT_BITS        = i2cmts_pkg::COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: commands and bus status events
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic        in_is_read,
  input  logic [6:0]  in_device_address,
  input  logic [31:0] in_register_address,
  input  logic [2:0]  in_register_address_bytes,
  input  logic [15:0] in_byte_count,
  input  logic [7:0]  in_status_code,
  input  logic [7:0]  in_bus_byte,
  input  logic [7:0]  in_tx_byte,
  // Result channel: one action per accepted transaction
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_out_byte,
  output logic [7:0]  out_rx_byte,
  output logic        out_rx_valid,
  output logic        out_done_res,
  output logic [1:0]  out_error_code
);

  i2cmts_pkg::result_t res;
  i2cmts_pkg::result_t res_r;
  logic                out_valid_r;
  logic                accept;
  logic                busy;

  // Hold the input only while a result sits in the register and is not taken;
  // a result being taken this cycle frees the slot for the next transaction.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  i2cmts_core #(
    .MAX_ADDRESS_BYTES(MAX_ADDRESS_BYTES),
    .COUNT_BITS       (COUNT_BITS)
  ) u_core (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .accept                (accept),
    .mode                  (in_mode),
    .is_read               (in_is_read),
    .device_address        (in_device_address),
    .register_address      (in_register_address),
    .register_address_bytes(in_register_address_bytes),
    .byte_count            (in_byte_count),
    .status_code           (in_status_code),
    .bus_byte              (in_bus_byte),
    .tx_byte               (in_tx_byte),
    .res                   (res),
    .busy                  (busy)
  );

  // Result register: load on accept, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; it only changes on accept, never while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = res_r.action;
  assign out_out_byte   = res_r.out_byte;
  assign out_rx_byte    = res_r.rx_byte;
  assign out_rx_valid   = res_r.rx_valid;
  assign out_done_res   = res_r.done_res;
  assign out_error_code = res_r.error_code;

  // An error is only ever reported with the end of a transaction.
  a_err_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.error_code != i2cmts_pkg::ERR_OK) |-> res_r.done_res)
    else $error("error code without transaction end");

  // A transmit byte only travels with a send action.
  a_byte_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.action != i2cmts_pkg::ACT_SEND) |-> (res_r.out_byte == 8'h00))
    else $error("out_byte set without send action");

  // A transaction end returns the sequencer to idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.done_res) |=> !busy)
    else $error("sequencer still busy after transaction end");

  // A start action is only given from idle, and leaves the sequencer busy.
  a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.action == i2cmts_pkg::ACT_START) |-> (!busy ##1 busy))
    else $error("start issued while a transaction was active");

endmodule
